>>> src/hrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrm_pkg;

	localparam int MAX_REFS_DEF  = 1024;
	localparam int DESC_BITS_DEF = 256;

	localparam int DIST_W      = 9;
	localparam int REF_IDX_W   = 10;
	localparam int QIDX_W      = 16;
	localparam int RATIO_W     = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;

	localparam logic [DIST_W-1:0]  NO_DIST       = DIST_W'(257);
	localparam logic [RATIO_W-1:0] RATIO_RESET   = RATIO_W'(192);
	localparam logic [DIST_W-1:0]  MAX_DIST_RESET = DIST_W'(80);

	localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_LOADED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_CLEARED = 3'd2,
		ST_MATCH   = 3'd3,
		ST_NOMATCH = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] desc_word0;
		logic [63:0] desc_word1;
		logic [63:0] desc_word2;
		logic [63:0] desc_word3;
	} item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [QIDX_W-1:0]    query_index;
		logic [REF_IDX_W-1:0] ref_index;
		logic [DIST_W-1:0]    best_distance;
		logic [DIST_W-1:0]    second_distance;
	} result_t;

	function automatic logic [6:0] popcount64(input logic [63:0] x);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
		logic [63:0] e;
		logic [63:0] f;
		a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
		b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
		c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
		d = c + (c >> 8);
		e = d + (d >> 16);
		f = e + (e >> 32);
		return f[6:0];
	endfunction

endpackage

`default_nettype wire

>>> src/hrm_store.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_store
	import hrm_pkg::*;
#(
	parameter int MAX_REFS  = MAX_REFS_DEF,
	parameter int DESC_BITS = DESC_BITS_DEF,
	localparam int IDX_W    = $clog2(MAX_REFS)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire logic [DESC_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output logic      [DESC_BITS-1:0] rd_data
);

	logic [DESC_BITS-1:0] mem_q [MAX_REFS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/hrm_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_dist
	import hrm_pkg::*;
#(
	parameter int MAX_REFS  = MAX_REFS_DEF,
	parameter int DESC_BITS = DESC_BITS_DEF,
	localparam int IDX_W    = $clog2(MAX_REFS),
	localparam int WORDS    = (DESC_BITS + 63) / 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [IDX_W-1:0]     in_idx,
	input  wire logic [DESC_BITS-1:0] query,
	input  wire logic [DESC_BITS-1:0] row,
	output logic                      out_valid,
	output logic      [IDX_W-1:0]     out_idx,
	output logic      [DIST_W-1:0]    ham_dist
);

	logic [WORDS*64-1:0] diff;
	logic [6:0]          part_s2 [WORDS];
	logic                valid_s2;
	logic [IDX_W-1:0]    idx_s2;

	assign diff = (WORDS*64)'(query ^ row);

	for (genvar w = 0; w < WORDS; w++) begin : g_word
		always_ff @(posedge clk) begin
			part_s2[w] <= popcount64(diff[w*64 +: 64]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
	end

	always_comb begin
		ham_dist = '0;
		for (int w = 0; w < WORDS; w++) begin
			ham_dist = ham_dist + DIST_W'(part_s2[w]);
		end
	end

	assign out_valid = valid_s2;
	assign out_idx   = idx_s2;

endmodule

`default_nettype wire

>>> src/hamming_ratio_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// ------    ---------------------  -----------------------------------------
// command   start / busy           item   (opcode, desc_word0..3)
// result    done strobe            result (status, indexes, distances)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Clear and load beats never raise busy, and neither does a query on an empty table.
// A query on N stored references keeps busy high while it issues one read per cycle
// from the single reference memory port, then while it drains the memory read and
// the distance pipeline and settles the ratio test.
// The result beat comes in the first cycle with busy low.
// Reset is asynchronous and empties the table; the reference memory is not cleared.
// The result is shown for one cycle only, since the receiver cannot stall.

module hamming_ratio_matcher_unit
	import hrm_pkg::*;
#(
	parameter int MAX_REFS  = MAX_REFS_DEF,
	parameter int DESC_BITS = DESC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire item_t                 item,
	output logic                       done,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_REFS);
	localparam int CNT_W = $clog2(MAX_REFS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [QIDX_W-1:0]    qcount_q;
	logic [QIDX_W-1:0]    qidx_q;
	logic [IDX_W-1:0]     addr_q;
	logic [DESC_BITS-1:0] query_q;
	logic [DIST_W-1:0]    best_q;
	logic [DIST_W-1:0]    second_q;
	logic [IDX_W-1:0]     ridx_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [RATIO_W-1:0]   ratio_q;
	logic [DIST_W-1:0]    max_dist_q;
	logic                 done_q;
	result_t              result_q;

	logic                 accept;
	logic                 full;
	logic                 wr_en;
	logic                 rd_en;
	logic [255:0]         in_bits;
	logic [DESC_BITS-1:0] row;
	logic                 dist_valid;
	logic [IDX_W-1:0]     dist_idx;
	logic [DIST_W-1:0]    ham_dist;
	logic                 last_issue;
	logic [17:0]          rhs;
	logic [17:0]          lhs;
	logic                 matched;

	assign accept     = start && !busy;
	assign busy       = (state_q != S_IDLE);
	assign full       = (count_q >= CNT_W'(MAX_REFS));
	assign in_bits    = {item.desc_word3, item.desc_word2, item.desc_word1, item.desc_word0};
	assign wr_en      = accept && (item.opcode == OP_LOAD) && !full;
	assign rd_en      = (state_q == S_SCAN);
	assign last_issue = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);
	assign rhs        = 18'(ratio_q * second_q);
	assign lhs        = {1'b0, best_q, 8'b0};
	assign matched    = (best_q < max_dist_q) && (lhs < rhs);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign result     = result_q;

	hrm_store #(
		.MAX_REFS  (MAX_REFS),
		.DESC_BITS (DESC_BITS)
	) u_store (
		.clk     (clk),
		.we      (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (in_bits[DESC_BITS-1:0]),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (row)
	);

	hrm_dist #(
		.MAX_REFS  (MAX_REFS),
		.DESC_BITS (DESC_BITS)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_idx    (idx_s1),
		.query     (query_q),
		.row       (row),
		.out_valid (dist_valid),
		.out_idx   (dist_idx),
		.ham_dist  (ham_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q    <= RATIO_RESET;
			max_dist_q <= MAX_DIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RATIO) begin
				ratio_q <= cfg_data;
			end else if (cfg_index == CFG_MAX_DIST) begin
				max_dist_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			qcount_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.opcode)
							OP_CLEAR: begin
								count_q  <= '0;
								qcount_q <= '0;
								done_q   <= 1'b1;
							end
							OP_LOAD: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								done_q <= 1'b1;
							end
							OP_QUERY: begin
								qcount_q <= qcount_q + QIDX_W'(1);
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!valid_s1 && !dist_valid) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				addr_q   <= '0;
				best_q   <= NO_DIST;
				second_q <= NO_DIST;
				ridx_q   <= '0;
				qidx_q   <= qcount_q;
				query_q  <= in_bits[DESC_BITS-1:0];
				result_q <= '0;
				if (accept) begin
					unique case (item.opcode)
						OP_CLEAR: begin
							result_q.status <= ST_CLEARED;
						end
						OP_LOAD: begin
							if (full) begin
								result_q.status <= ST_DROPPED;
							end else begin
								result_q.status    <= ST_LOADED;
								result_q.ref_index <= REF_IDX_W'(count_q);
							end
						end
						OP_QUERY: begin
							result_q.status          <= ST_NOMATCH;
							result_q.query_index     <= qcount_q;
							result_q.best_distance   <= NO_DIST;
							result_q.second_distance <= NO_DIST;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN, S_DRAIN: begin
				if (!last_issue) begin
					addr_q <= addr_q + IDX_W'(1);
				end
				if (dist_valid) begin
					if (ham_dist < best_q) begin
						second_q <= best_q;
						best_q   <= ham_dist;
						ridx_q   <= dist_idx;
					end else if (ham_dist < second_q) begin
						second_q <= ham_dist;
					end
				end
				if (state_q == S_DRAIN && !valid_s1 && !dist_valid) begin
					result_q.status          <= matched ? ST_MATCH : ST_NOMATCH;
					result_q.query_index     <= qidx_q;
					result_q.ref_index       <= REF_IDX_W'(ridx_q);
					result_q.best_distance   <= best_q;
					result_q.second_distance <= second_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/hrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_checker
	import hrm_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire item_t                 item,
	input wire logic                  done,
	input wire result_t               result,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	a_no_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("result beat while busy");

	a_beat_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.opcode != 2'd3) |=> done || busy)
		else $error("accepted command neither answered nor in progress");

	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result beat");

	a_clear_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_CLEARED) |->
			(result.query_index == '0) && (result.ref_index == '0) &&
			(result.best_distance == '0) && (result.second_distance == '0))
		else $error("clear result carries nonzero fields");

	a_cfg_beat_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !$isunknown({cfg_index, cfg_data}))
		else $error("configuration beat with unknown index or data");

endmodule

bind hamming_ratio_matcher_unit hrm_checker u_hrm_checker (.*);

`default_nettype wire
